// ----- rtl/lcpcr_pkg.sv -----
// ----------------------------------------------------------------------------
// lcpcr_pkg
// Shared constants and controller/datapath types for the LCP
// Configure-Request responder.
// ----------------------------------------------------------------------------
package lcpcr_pkg;

    localparam int OPTION_BYTES = 48;
    localparam int MAX_OPTIONS  = 24;

    localparam int HELD_W = $clog2(OPTION_BYTES + 1);
    localparam int IDX_W  = $clog2(OPTION_BYTES);
    localparam int CNT_W  = $clog2(MAX_OPTIONS + 1);
    localparam int OIDX_W = $clog2(MAX_OPTIONS);
    localparam int LEN_W  = 6;
    localparam int HIDX_W = 4;

    localparam logic [15:0] MRU_RESET = 16'd1492;

    // LCP codes
    localparam logic [7:0] CODE_ACK    = 8'h02;
    localparam logic [7:0] CODE_NAK    = 8'h03;
    localparam logic [7:0] CODE_REJECT = 8'h04;

    // option types and lengths
    localparam logic [7:0] OPT_MRU       = 8'h01;
    localparam logic [7:0] OPT_MAGIC     = 8'h05;
    localparam logic [7:0] MRU_OPT_LEN   = 8'h04;
    localparam logic [7:0] MAGIC_OPT_LEN = 8'h06;

    typedef enum logic [1:0] {
        MARK_ACCEPT = 2'd0,
        MARK_NAK    = 2'd1,
        MARK_REJECT = 2'd2
    } mark_t;

    typedef enum logic [2:0] {
        PH_TYPE   = 3'b001,
        PH_LENGTH = 3'b010,
        PH_VALUE  = 3'b100
    } phase_t;

    typedef struct packed {
        logic take;
        logic hdr_step;
        logic tbl_read;
        logic skip_opt;
        logic byte_read;
        logic byte_step;
        logic emit_ovf;
        logic clear;
    } dp_cmd_t;

    typedef struct packed {
        logic ovf;
        logic hdr_last;
        logic walk_done;
        logic selected;
        logic byte_last;
    } dp_status_t;

endpackage

// ----- rtl/lcpcr_datapath.sv -----
// ----------------------------------------------------------------------------
// lcpcr_datapath
// Option parser, option byte store, option table and reply byte generator.
// ----------------------------------------------------------------------------
module lcpcr_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [15:0]                   cfg_wr_data,
    input  logic [7:0]                    option_byte,
    input  logic                          has_byte,
    input  logic [7:0]                    request_id,
    input  logic [31:0]                   peer_magic,
    input  logic                          end_of_request,
    input  lcpcr_pkg::dp_cmd_t            cmd,
    output lcpcr_pkg::dp_status_t         status,
    output logic                          reply_valid,
    output logic [7:0]                    reply_byte,
    output logic                          reply_last,
    output logic [lcpcr_pkg::LEN_W-1:0]   reply_length,
    output logic                          reply_status
);

    localparam int HW = lcpcr_pkg::HELD_W;
    localparam int IW = lcpcr_pkg::IDX_W;
    localparam int CW = lcpcr_pkg::CNT_W;
    localparam int OW = lcpcr_pkg::OIDX_W;
    localparam int LW = lcpcr_pkg::LEN_W;
    localparam int XW = lcpcr_pkg::HIDX_W;
    localparam int TW = 2 + HW;

    // memories
    logic [7:0]    store_mem [lcpcr_pkg::OPTION_BYTES];
    logic [TW-1:0] tbl_mem   [lcpcr_pkg::MAX_OPTIONS];
    logic [7:0]    store_rd_reg;
    logic [TW-1:0] tbl_rd_reg;

    // parse state
    logic [HW-1:0]         held_reg, held_next;
    lcpcr_pkg::phase_t     phase_reg, phase_next;
    logic [7:0]            left_reg, left_next;
    logic                  rej_reg, rej_next;
    logic                  nak_reg, nak_next;
    logic                  mru_seen_reg, mru_seen_next;
    logic                  magic_seen_reg, magic_seen_next;
    logic                  ovf_reg, ovf_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [HW-1:0]         rej_sum_reg, rej_sum_next;
    logic [HW-1:0]         nak_sum_reg, nak_sum_next;
    logic [7:0]            type_reg, type_next;
    logic [7:0]            len_reg, len_next;
    logic [7:0]            v0_reg, v0_next;
    logic [7:0]            v1_reg, v1_next;
    logic [HW-1:0]         occ_reg, occ_next;
    logic [15:0]           mru_cfg_reg;
    logic [7:0]            id_reg;
    logic [31:0]           magic_reg;

    // reply walk state
    logic [XW-1:0]         hidx_reg, hidx_next;
    logic [CW-1:0]         k_reg, k_next;
    logic [HW-1:0]         pos_reg, pos_next;
    logic [HW-1:0]         t_reg, t_next;
    logic [LW-1:0]         nout_reg, nout_next;

    logic                  store_we;
    logic                  tbl_we;
    logic [TW-1:0]         tbl_wdata;
    logic                  close_now;
    logic                  close_opt;
    lcpcr_pkg::mark_t      new_mark;

    logic [7:0]            code;
    logic                  add_mru;
    logic                  add_mag;
    logic [HW-1:0]         sel_sum;
    logic [LW-1:0]         total;
    logic [XW-1:0]         hlen;
    logic [XW-1:0]         hj;
    logic [XW-1:0]         hjj;
    logic [7:0]            hdr_byte;
    logic [7:0]            opt_byte;
    logic [1:0]            rd_mark;
    logic [HW-1:0]         rd_occ;
    logic [HW-1:0]         rd_addr;
    logic                  out_last;
    logic                  sel_hit;

    assign rd_mark = tbl_rd_reg[TW-1 -: 2];
    assign rd_occ  = tbl_rd_reg[HW-1:0];

    // ------------------------------------------------------------------
    // reply code and length
    // ------------------------------------------------------------------
    always_comb
    begin
        if (rej_reg)
        begin
            code = lcpcr_pkg::CODE_REJECT;
        end
        else if (nak_reg || !mru_seen_reg || !magic_seen_reg)
        begin
            code = lcpcr_pkg::CODE_NAK;
        end
        else
        begin
            code = lcpcr_pkg::CODE_ACK;
        end
    end

    assign add_mru = (code == lcpcr_pkg::CODE_NAK) && !mru_seen_reg;
    assign add_mag = (code == lcpcr_pkg::CODE_NAK) && !magic_seen_reg;

    always_comb
    begin
        case (code)
            lcpcr_pkg::CODE_REJECT: sel_sum = rej_sum_reg;
            lcpcr_pkg::CODE_NAK:    sel_sum = nak_sum_reg;
            default:                sel_sum = held_reg;
        endcase
    end

    assign total = LW'(4) + (add_mru ? LW'(4) : LW'(0)) + (add_mag ? LW'(6) : LW'(0))
                 + LW'(sel_sum);
    assign hlen  = XW'(4) + (add_mru ? XW'(4) : XW'(0)) + (add_mag ? XW'(6) : XW'(0));
    assign hj    = hidx_reg - XW'(4);
    assign hjj   = add_mru ? hj - XW'(4) : hj;

    // header, then the added MRU and magic options of a Nak
    always_comb
    begin
        hdr_byte = 8'h00;
        case (hidx_reg)
            XW'(0): hdr_byte = code;
            XW'(1): hdr_byte = id_reg;
            XW'(2): hdr_byte = 8'h00;
            XW'(3): hdr_byte = 8'(total);
            default:
            begin
                if (add_mru && hj < XW'(4))
                begin
                    case (hj[1:0])
                        2'd0:    hdr_byte = lcpcr_pkg::OPT_MRU;
                        2'd1:    hdr_byte = lcpcr_pkg::MRU_OPT_LEN;
                        2'd2:    hdr_byte = mru_cfg_reg[15:8];
                        default: hdr_byte = mru_cfg_reg[7:0];
                    endcase
                end
                else
                begin
                    case (hjj)
                        XW'(0):  hdr_byte = lcpcr_pkg::OPT_MAGIC;
                        XW'(1):  hdr_byte = lcpcr_pkg::MAGIC_OPT_LEN;
                        XW'(2):  hdr_byte = magic_reg[31:24];
                        XW'(3):  hdr_byte = magic_reg[23:16];
                        XW'(4):  hdr_byte = magic_reg[15:8];
                        XW'(5):  hdr_byte = magic_reg[7:0];
                        default: hdr_byte = 8'h00;
                    endcase
                end
            end
        endcase
    end

    // clamped MRU replaces value bytes 0 and 1
    always_comb
    begin
        opt_byte = store_rd_reg;
        if (rd_mark == lcpcr_pkg::MARK_NAK && t_reg == HW'(2))
        begin
            opt_byte = mru_cfg_reg[15:8];
        end
        else if (rd_mark == lcpcr_pkg::MARK_NAK && t_reg == HW'(3))
        begin
            opt_byte = mru_cfg_reg[7:0];
        end
    end

    always_comb
    begin
        case (code)
            lcpcr_pkg::CODE_REJECT: sel_hit = (rd_mark == lcpcr_pkg::MARK_REJECT);
            lcpcr_pkg::CODE_NAK:    sel_hit = (rd_mark == lcpcr_pkg::MARK_NAK);
            default:                sel_hit = 1'b1;
        endcase
    end

    assign status.selected  = sel_hit;
    assign status.ovf       = ovf_reg;
    assign status.hdr_last  = (hidx_reg == hlen - XW'(1));
    assign status.walk_done = (k_reg == count_reg);
    assign status.byte_last = (t_reg + HW'(1) == rd_occ);

    assign rd_addr  = pos_reg + t_reg;
    assign out_last = (nout_reg + LW'(1) == total);

    // ------------------------------------------------------------------
    // parser and walk counters
    // ------------------------------------------------------------------
    always_comb
    begin
        held_next       = held_reg;
        phase_next      = phase_reg;
        left_next       = left_reg;
        rej_next        = rej_reg;
        nak_next        = nak_reg;
        mru_seen_next   = mru_seen_reg;
        magic_seen_next = magic_seen_reg;
        ovf_next        = ovf_reg;
        count_next      = count_reg;
        rej_sum_next    = rej_sum_reg;
        nak_sum_next    = nak_sum_reg;
        type_next       = type_reg;
        len_next        = len_reg;
        v0_next         = v0_reg;
        v1_next         = v1_reg;
        occ_next        = occ_reg;
        hidx_next       = hidx_reg;
        k_next          = k_reg;
        pos_next        = pos_reg;
        t_next          = t_reg;
        nout_next       = nout_reg;
        store_we        = 1'b0;
        tbl_we          = 1'b0;
        tbl_wdata       = '0;
        close_now       = 1'b0;
        close_opt       = 1'b0;
        new_mark        = lcpcr_pkg::MARK_ACCEPT;

        if (cmd.take)
        begin
            if (has_byte && !ovf_reg)
            begin
                if (held_reg == HW'(lcpcr_pkg::OPTION_BYTES) ||
                    (phase_reg == lcpcr_pkg::PH_TYPE &&
                     count_reg == CW'(lcpcr_pkg::MAX_OPTIONS)))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    store_we  = 1'b1;
                    held_next = held_reg + HW'(1);
                    case (phase_reg)
                        lcpcr_pkg::PH_TYPE:
                        begin
                            type_next  = option_byte;
                            len_next   = 8'h00;
                            v0_next    = 8'h00;
                            v1_next    = 8'h00;
                            occ_next   = HW'(1);
                            phase_next = lcpcr_pkg::PH_LENGTH;
                        end
                        lcpcr_pkg::PH_LENGTH:
                        begin
                            len_next = option_byte;
                            occ_next = occ_reg + HW'(1);
                            if (option_byte > 8'd2)
                            begin
                                left_next  = option_byte - 8'd2;
                                phase_next = lcpcr_pkg::PH_VALUE;
                            end
                            else
                            begin
                                close_now = 1'b1;
                            end
                        end
                        lcpcr_pkg::PH_VALUE:
                        begin
                            occ_next  = occ_reg + HW'(1);
                            left_next = left_reg - 8'd1;
                            if (occ_reg == HW'(2))
                            begin
                                v0_next = option_byte;
                            end
                            if (occ_reg == HW'(3))
                            begin
                                v1_next = option_byte;
                            end
                            if (left_reg == 8'd1)
                            begin
                                close_now = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // a request that ends mid-option closes it with what arrived
            close_opt = close_now ||
                        (end_of_request && !ovf_next && phase_next != lcpcr_pkg::PH_TYPE);

            if (close_opt)
            begin
                if (type_next == lcpcr_pkg::OPT_MRU)
                begin
                    mru_seen_next = 1'b1;
                    if (len_next != lcpcr_pkg::MRU_OPT_LEN)
                    begin
                        nak_next = 1'b1;
                    end
                    if ({v0_next, v1_next} > mru_cfg_reg)
                    begin
                        new_mark = lcpcr_pkg::MARK_NAK;
                        nak_next = 1'b1;
                    end
                end
                else if (type_next == lcpcr_pkg::OPT_MAGIC)
                begin
                    magic_seen_next = 1'b1;
                end
                else
                begin
                    new_mark = lcpcr_pkg::MARK_REJECT;
                    rej_next = 1'b1;
                end
                tbl_we     = 1'b1;
                tbl_wdata  = {new_mark, occ_next};
                count_next = count_reg + CW'(1);
                phase_next = lcpcr_pkg::PH_TYPE;
                left_next  = 8'h00;
                if (new_mark == lcpcr_pkg::MARK_REJECT)
                begin
                    rej_sum_next = rej_sum_reg + occ_next;
                end
                if (new_mark == lcpcr_pkg::MARK_NAK)
                begin
                    nak_sum_next = nak_sum_reg + occ_next;
                end
            end
        end

        if (cmd.hdr_step)
        begin
            hidx_next = hidx_reg + XW'(1);
            nout_next = nout_reg + LW'(1);
        end

        if (cmd.byte_step)
        begin
            nout_next = nout_reg + LW'(1);
            t_next    = t_reg + HW'(1);
            if (status.byte_last)
            begin
                t_next   = '0;
                pos_next = pos_reg + rd_occ;
                k_next   = k_reg + CW'(1);
            end
        end

        if (cmd.skip_opt)
        begin
            pos_next = pos_reg + rd_occ;
            k_next   = k_reg + CW'(1);
        end

        if (cmd.clear)
        begin
            held_next       = '0;
            phase_next      = lcpcr_pkg::PH_TYPE;
            left_next       = 8'h00;
            rej_next        = 1'b0;
            nak_next        = 1'b0;
            mru_seen_next   = 1'b0;
            magic_seen_next = 1'b0;
            ovf_next        = 1'b0;
            count_next      = '0;
            rej_sum_next    = '0;
            nak_sum_next    = '0;
            hidx_next       = '0;
            k_next          = '0;
            pos_next        = '0;
            t_next          = '0;
            nout_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= '0;
            phase_reg      <= lcpcr_pkg::PH_TYPE;
            left_reg       <= 8'h00;
            rej_reg        <= 1'b0;
            nak_reg        <= 1'b0;
            mru_seen_reg   <= 1'b0;
            magic_seen_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            count_reg      <= '0;
            rej_sum_reg    <= '0;
            nak_sum_reg    <= '0;
            hidx_reg       <= '0;
            k_reg          <= '0;
            pos_reg        <= '0;
            t_reg          <= '0;
            nout_reg       <= '0;
            mru_cfg_reg    <= lcpcr_pkg::MRU_RESET;
            reply_valid    <= 1'b0;
        end
        else
        begin
            held_reg       <= held_next;
            phase_reg      <= phase_next;
            left_reg       <= left_next;
            rej_reg        <= rej_next;
            nak_reg        <= nak_next;
            mru_seen_reg   <= mru_seen_next;
            magic_seen_reg <= magic_seen_next;
            ovf_reg        <= ovf_next;
            count_reg      <= count_next;
            rej_sum_reg    <= rej_sum_next;
            nak_sum_reg    <= nak_sum_next;
            hidx_reg       <= hidx_next;
            k_reg          <= k_next;
            pos_reg        <= pos_next;
            t_reg          <= t_next;
            nout_reg       <= nout_next;
            if (cfg_wr_en)
            begin
                mru_cfg_reg <= cfg_wr_data;
            end
            reply_valid    <= cmd.hdr_step || cmd.byte_step || cmd.emit_ovf;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        len_reg  <= len_next;
        v0_reg   <= v0_next;
        v1_reg   <= v1_next;
        occ_reg  <= occ_next;
        if (cmd.take && end_of_request)
        begin
            id_reg    <= request_id;
            magic_reg <= peer_magic;
        end
        if (cmd.emit_ovf)
        begin
            reply_byte   <= 8'h00;
            reply_last   <= 1'b1;
            reply_length <= '0;
            reply_status <= 1'b1;
        end
        else if (cmd.hdr_step)
        begin
            reply_byte   <= hdr_byte;
            reply_last   <= out_last;
            reply_length <= total;
            reply_status <= 1'b0;
        end
        else if (cmd.byte_step)
        begin
            reply_byte   <= opt_byte;
            reply_last   <= out_last;
            reply_length <= total;
            reply_status <= 1'b0;
        end
    end

    // option byte store
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[held_reg[IW-1:0]] <= option_byte;
        end
        if (cmd.byte_read)
        begin
            store_rd_reg <= store_mem[rd_addr[IW-1:0]];
        end
    end

    // option table: mark and occupied byte count per option
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[count_reg[OW-1:0]] <= tbl_wdata;
        end
        if (cmd.tbl_read)
        begin
            tbl_rd_reg <= tbl_mem[k_reg[OW-1:0]];
        end
    end

endmodule

// ----- rtl/lcpcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// lcpcr_ctrl
// Sequencer: takes request bytes, then walks header and option table to
// produce the reply.
// ----------------------------------------------------------------------------
module lcpcr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   end_of_request,
    input  lcpcr_pkg::dp_status_t  status,
    output lcpcr_pkg::dp_cmd_t     cmd,
    output logic                   busy
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_LAUNCH   = 7'b0000010,
        ST_HDR      = 7'b0000100,
        ST_TBL_RD   = 7'b0001000,
        ST_TBL_CHK  = 7'b0010000,
        ST_BYTE_RD  = 7'b0100000,
        ST_BYTE_OUT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take = start;
                if (start && end_of_request)
                begin
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH:
            begin
                if (status.ovf)
                begin
                    cmd.emit_ovf = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HDR;
                end
            end
            ST_HDR:
            begin
                cmd.hdr_step = 1'b1;
                if (status.hdr_last)
                begin
                    state_next = ST_TBL_RD;
                end
            end
            ST_TBL_RD:
            begin
                if (status.walk_done)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.tbl_read = 1'b1;
                    state_next   = ST_TBL_CHK;
                end
            end
            ST_TBL_CHK:
            begin
                if (status.selected)
                begin
                    state_next = ST_BYTE_RD;
                end
                else
                begin
                    cmd.skip_opt = 1'b1;
                    state_next   = ST_TBL_RD;
                end
            end
            ST_BYTE_RD:
            begin
                cmd.byte_read = 1'b1;
                state_next    = ST_BYTE_OUT;
            end
            ST_BYTE_OUT:
            begin
                cmd.byte_step = 1'b1;
                state_next    = status.byte_last ? ST_TBL_RD : ST_BYTE_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- rtl/lcp_configure_request_responder_unit.sv -----
// ----------------------------------------------------------------------------
// lcp_configure_request_responder_unit
// Server side LCP Configure-Request handling: parses the options area and
// emits a Configure-Ack, -Nak or -Reject one byte per result.
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------------
//  config    | cfg_wr_en             | cfg_wr_data (max_receive_unit)
//  request   | start & !busy         | option_byte, has_byte, request_id,
//            |                       | peer_magic, end_of_request
//  reply     | reply_valid strobe    | reply_byte, reply_last, reply_length,
//            |                       | reply_status
//
//  Option bytes are taken one per cycle while busy is low. The final request
//  raises busy for the reply: a launch state, a header state per header and
//  added option byte, a table read and a table check state per option table
//  entry and a byte read and a byte output state per echoed byte, then a
//  table read that finds the table walked, as the option store and table are
//  single read port memories with registered read. An overflowed request
//  holds busy through the launch state only. Reply bytes appear in the cycle
//  after they are produced and hold for one cycle only; the receiver cannot stall.
//  Reset is asynchronous, active low, and leaves max_receive_unit at 1492.
// ----------------------------------------------------------------------------
module lcp_configure_request_responder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [15:0]                   cfg_wr_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [7:0]                    option_byte,
    input  logic                          has_byte,
    input  logic [7:0]                    request_id,
    input  logic [31:0]                   peer_magic,
    input  logic                          end_of_request,
    output logic                          reply_valid,
    output logic [7:0]                    reply_byte,
    output logic                          reply_last,
    output logic [lcpcr_pkg::LEN_W-1:0]   reply_length,
    output logic                          reply_status
);

    lcpcr_pkg::dp_cmd_t    cmd;
    lcpcr_pkg::dp_status_t status;

    lcpcr_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .end_of_request (end_of_request),
        .status         (status),
        .cmd            (cmd),
        .busy           (busy)
    );

    lcpcr_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .option_byte    (option_byte),
        .has_byte       (has_byte),
        .request_id     (request_id),
        .peer_magic     (peer_magic),
        .end_of_request (end_of_request),
        .cmd            (cmd),
        .status         (status),
        .reply_valid    (reply_valid),
        .reply_byte     (reply_byte),
        .reply_last     (reply_last),
        .reply_length   (reply_length),
        .reply_status   (reply_status)
    );

endmodule
